>>> hdl/anim_pkg.sv
package anim_pkg;

    localparam int COS_DEPTH_DEF = 256;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_STOP    = 3'd3;
    localparam logic [2:0] OP_PAUSE   = 3'd4;
    localparam logic [2:0] OP_RESUME  = 3'd5;

    localparam logic [2:0] CRV_LINEAR     = 3'd0;
    localparam logic [2:0] CRV_INOUT      = 3'd1;
    localparam logic [2:0] CRV_IN         = 3'd2;
    localparam logic [2:0] CRV_OUT        = 3'd3;
    localparam logic [2:0] CRV_CYCLE      = 3'd4;
    localparam logic [2:0] CRV_BOUNCE     = 3'd5;
    localparam logic [2:0] CRV_ANTICIPATE = 3'd6;
    localparam logic [2:0] CRV_OVERSHOOT  = 3'd7;

    localparam logic [2:0] REG_DURATION = 3'd0;
    localparam logic [2:0] REG_DELAY    = 3'd1;
    localparam logic [2:0] REG_REPEAT   = 3'd2;
    localparam logic [2:0] REG_REVERSE  = 3'd3;
    localparam logic [2:0] REG_CURVE    = 3'd4;
    localparam logic [2:0] REG_TENSION  = 3'd5;
    localparam logic [2:0] REG_CYCLES   = 3'd6;
    localparam logic [2:0] REG_UPDATE   = 3'd7;

    localparam longint unsigned PI_Q28 = 64'd843314857;

    typedef struct packed {
        logic [15:0]        duration_ms;
        logic [15:0]        delay_ms;
        logic signed [15:0] repeat_count;
        logic               auto_reverse;
        logic [2:0]         curve_select;
        logic [15:0]        tension;
        logic [15:0]        cycles;
        logic               update_on_start;
    } cfg_t;

    typedef struct packed {
        logic take;
        logic dec;
        logic nofr;
        logic sub;
        logic chk;
        logic div_start;
        logic div_sel;
        logic res;
        logic rev;
        logic rep;
        logic ldf;
        logic mul1;
        logic post1;
        logic adj;
        logic mul2;
        logic post2;
        logic mul3;
        logic post3;
        logic fin;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic frame_req;
        logic t_ge_dur;
        logic rep_zero;
        logic div_done;
    } sts_t;

    // round to nearest, halves away from zero, Q16 drop
    function automatic logic signed [51:0] rnd16(input logic signed [51:0] p);
        logic signed [51:0] m;
        m = -p;
        if (p < 0)
            return -((m + 52'sd32768) >>> 16);
        return (p + 52'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] rnd2(input logic signed [31:0] v);
        logic signed [31:0] m;
        m = -v;
        if (v < 0)
            return -((m + 32'sd2) >>> 2);
        return (v + 32'sd2) >>> 2;
    endfunction

    // Taylor series of cos(x), x in Q28 radians, result Q16
    function automatic logic signed [17:0] cos_series(input longint unsigned x,
                                                       input logic neg);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          c;
        x2   = (x * x) >> 28;
        term = 64'd1 << 28;
        sum  = longint'(term);
        term = ((term * x2) >> 28) / 2;   sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 12;  sum = sum + longint'(term);
        term = ((term * x2) >> 28) / 30;  sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 56;  sum = sum + longint'(term);
        term = ((term * x2) >> 28) / 90;  sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 132; sum = sum + longint'(term);
        term = ((term * x2) >> 28) / 182; sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 240; sum = sum + longint'(term);
        term = ((term * x2) >> 28) / 306; sum = sum - longint'(term);
        if (sum < 0)
            sum = 0;
        c = (sum + 64'sd2048) >>> 12;
        if (neg)
            c = -c;
        return 18'(c);
    endfunction

endpackage

>>> hdl/anim_in_if.sv
interface anim_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] value_ms;

    modport source (output valid, opcode, value_ms, input ready);
    modport sink   (input valid, opcode, value_ms, output ready);
endinterface

>>> hdl/anim_out_if.sv
interface anim_out_if;
    logic               valid;
    logic               ready;
    logic               frame_valid;
    logic [15:0]        position_ms;
    logic signed [15:0] fraction;
    logic               repeat_event;
    logic signed [15:0] remaining_repeats;
    logic               stop_event;

    modport source (output valid, frame_valid, position_ms, fraction, repeat_event,
                    remaining_repeats, stop_event, input ready);
    modport sink   (input valid, frame_valid, position_ms, fraction, repeat_event,
                    remaining_repeats, stop_event, output ready);
endinterface

>>> hdl/anim_regs.sv
module anim_regs
    import anim_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duration_ms     <= 16'd1000;
            cfg_reg.delay_ms        <= 16'd0;
            cfg_reg.repeat_count    <= 16'sd0;
            cfg_reg.auto_reverse    <= 1'b0;
            cfg_reg.curve_select    <= CRV_LINEAR;
            cfg_reg.tension         <= 16'd8192;
            cfg_reg.cycles          <= 16'd256;
            cfg_reg.update_on_start <= 1'b1;
        end
        else if (wr)
        begin
            unique case (paddr[4:2])
                REG_DURATION: cfg_reg.duration_ms     <= pwdata[15:0];
                REG_DELAY:    cfg_reg.delay_ms        <= pwdata[15:0];
                REG_REPEAT:   cfg_reg.repeat_count    <= $signed(pwdata[15:0]);
                REG_REVERSE:  cfg_reg.auto_reverse    <= pwdata[0];
                REG_CURVE:    cfg_reg.curve_select    <= pwdata[2:0];
                REG_TENSION:  cfg_reg.tension         <= pwdata[15:0];
                REG_CYCLES:   cfg_reg.cycles          <= pwdata[15:0];
                REG_UPDATE:   cfg_reg.update_on_start <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_DURATION: prdata = {16'd0, cfg_reg.duration_ms};
            REG_DELAY:    prdata = {16'd0, cfg_reg.delay_ms};
            REG_REPEAT:   prdata = {16'd0, cfg_reg.repeat_count};
            REG_REVERSE:  prdata = {31'd0, cfg_reg.auto_reverse};
            REG_CURVE:    prdata = {29'd0, cfg_reg.curve_select};
            REG_TENSION:  prdata = {16'd0, cfg_reg.tension};
            REG_CYCLES:   prdata = {16'd0, cfg_reg.cycles};
            REG_UPDATE:   prdata = {31'd0, cfg_reg.update_on_start};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

>>> hdl/anim_div.sv
module anim_div
    import anim_pkg::*;
#(
    parameter int DW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [15:0]   divisor,
    output logic [DW-1:0] quotient,
    output logic [15:0]   remainder,
    output logic          done
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dvd_reg;
    logic [15:0]   rem_reg;
    logic [15:0]   dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [16:0]   rem_sh;
    logic          qbit;
    logic [15:0]   rem_next;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[DW-1]};
        qbit     = (rem_sh >= {1'b0, dsr_reg});
        rem_next = qbit ? 16'(rem_sh - {1'b0, dsr_reg}) : rem_sh[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= 16'd0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = dvd_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

>>> hdl/anim_dpath.sv
module anim_dpath
    import anim_pkg::*;
#(
    parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF,
    parameter int TIME_BITS       = TIME_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic [2:0]         opcode,
    input  logic [15:0]        value_ms,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic               frame_valid,
    output logic [15:0]        position_ms,
    output logic signed [15:0] fraction,
    output logic               repeat_event,
    output logic signed [15:0] remaining_repeats,
    output logic               stop_event
);

    localparam int DW = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int IW = $clog2(COS_TABLE_DEPTH);

    // cosine table, built at elaboration
    logic signed [17:0] cos_rom [COS_TABLE_DEPTH];

    for (genvar k = 0; k < COS_TABLE_DEPTH; k++)
    begin : g_cos
        localparam longint unsigned N  = longint'(COS_TABLE_DEPTH);
        localparam longint unsigned A0 = 2 * longint'(k);
        localparam longint unsigned A1 = (A0 > N) ? 2 * N - A0 : A0;
        localparam bit              NG = (2 * A1 > N);
        localparam longint unsigned AA = NG ? N - A1 : A1;
        localparam longint unsigned XX = (PI_Q28 * AA + N / 2) / N;
        assign cos_rom[k] = cos_series(XX, NG);
    end

    // control state
    logic [TIME_BITS-1:0] elapsed_reg;
    logic                 started_reg;
    logic                 running_reg;
    logic [15:0]          last_rep_reg;

    // payload
    logic [2:0]           op_reg;
    logic [15:0]          val_reg;
    logic [TIME_BITS-1:0] t_reg;
    logic [TIME_BITS-1:0] q_reg;
    logic [15:0]          pos_reg;
    logic                 stop_reg;
    logic [16:0]          f_reg;
    logic signed [51:0]   prod_reg;
    logic signed [31:0]   r1_reg;
    logic signed [31:0]   r2_reg;
    logic signed [31:0]   r3_reg;
    logic [23:0]          ph_reg;
    logic signed [25:0]   d_reg;
    logic [16:0]          off_reg;
    logic [IW-1:0]        idx_reg;
    logic signed [17:0]   cos_reg;

    logic                 res_frame_reg;
    logic [15:0]          res_pos_reg;
    logic signed [15:0]   res_frac_reg;
    logic                 res_rev_reg;
    logic signed [15:0]   res_rem_reg;
    logic                 res_stop_reg;

    logic                 o_frame_reg;
    logic [15:0]          o_pos_reg;
    logic signed [15:0]   o_frac_reg;
    logic                 o_rev_reg;
    logic signed [15:0]   o_rem_reg;
    logic                 o_stop_reg;

    logic [15:0]          dur;
    logic [TIME_BITS:0]   acc_sum;
    logic [TIME_BITS-1:0] dly;
    logic                 rep_neg;
    logic                 frame_req;
    logic [DW-1:0]        div_dvd;
    logic [DW-1:0]        div_q;
    logic [15:0]          div_r;
    logic                 div_done;
    logic [TIME_BITS-1:0] rep_ext;
    logic [19:0]          tt;
    logic signed [25:0]   tt_s;
    logic signed [25:0]   tp_s;
    logic signed [25:0]   f_s;
    logic signed [25:0]   g3_s;
    logic signed [25:0]   g7_s;
    logic signed [25:0]   mul_a;
    logic signed [25:0]   mul_b;
    logic signed [31:0]   rq;
    logic [IW:0]          idx_full;
    logic signed [31:0]   cval;
    logic signed [31:0]   fr;

    assign dur      = (cfg.duration_ms == 16'd0) ? 16'd1 : cfg.duration_ms;
    assign acc_sum  = {1'b0, elapsed_reg} + (TIME_BITS + 1)'(val_reg);
    assign dly      = TIME_BITS'(cfg.delay_ms);
    assign rep_neg  = cfg.repeat_count[15];
    assign rep_ext  = TIME_BITS'(cfg.repeat_count[14:0]);
    assign tt       = {cfg.tension, 4'd0};
    assign tt_s     = $signed(26'(tt));
    assign tp_s     = tt_s + 26'sd65536;
    assign f_s      = $signed({9'd0, f_reg});
    assign g3_s     = 26'sd65536 - f_s;
    assign g7_s     = f_s - 26'sd65536;
    assign rq       = 32'(rnd16(prod_reg));
    assign idx_full = (IW + 1)'((prod_reg + 52'sd8388608) >>> 24);

    always_comb
    begin
        case (op_reg)
            OP_TICK:    frame_req = started_reg && running_reg;
            OP_START:   frame_req = !started_reg && cfg.update_on_start;
            OP_RESTART: frame_req = cfg.update_on_start;
            default:    frame_req = 1'b0;
        endcase
    end

    assign sts.frame_req = frame_req;
    assign sts.t_ge_dur  = (t_reg >= TIME_BITS'(dur));
    assign sts.rep_zero  = (cfg.repeat_count == 16'sd0);
    assign sts.div_done  = div_done;

    assign div_dvd = cmd.div_sel ? (DW'({pos_reg, 16'd0}) + DW'(dur[15:1])) : DW'(t_reg);

    anim_div #(.DW(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (dur),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = f_s;
        mul_b = 26'sd0;
        if (cmd.mul1)
        begin
            case (cfg.curve_select)
                CRV_INOUT:      mul_b = 26'sd128;
                CRV_CYCLE:      mul_b = $signed({10'd0, cfg.cycles});
                CRV_IN:         mul_b = f_s;
                CRV_ANTICIPATE: mul_b = f_s;
                CRV_OUT:
                begin
                    mul_a = g3_s;
                    mul_b = g3_s;
                end
                CRV_OVERSHOOT:
                begin
                    mul_a = g7_s;
                    mul_b = g7_s;
                end
                CRV_BOUNCE:     mul_b = 26'sd73571;
                default:        mul_b = 26'sd0;
            endcase
        end
        else if (cmd.mul2)
        begin
            case (cfg.curve_select)
                CRV_INOUT, CRV_CYCLE:
                begin
                    mul_a = $signed({2'd0, ph_reg});
                    mul_b = 26'(COS_TABLE_DEPTH);
                end
                CRV_BOUNCE:
                begin
                    mul_a = d_reg;
                    mul_b = d_reg;
                end
                CRV_ANTICIPATE:
                begin
                    mul_a = tp_s;
                    mul_b = f_s;
                end
                CRV_OVERSHOOT:
                begin
                    mul_a = tp_s;
                    mul_b = g7_s;
                end
                default:        mul_b = 26'sd0;
            endcase
        end
        else
        begin
            mul_a = 26'(r1_reg);
            mul_b = 26'(r2_reg);
        end
    end

    always_comb
    begin
        case (cfg.curve_select)
            CRV_INOUT, CRV_CYCLE: cval = (32'sd65537 - 32'(cos_reg)) >>> 1;
            CRV_IN:               cval = r1_reg;
            CRV_OUT:              cval = 32'sd65536 - r1_reg;
            CRV_BOUNCE:           cval = r2_reg;
            CRV_ANTICIPATE:       cval = r3_reg;
            CRV_OVERSHOOT:        cval = 32'sd65536 + r3_reg;
            default:              cval = 32'(f_s);
        endcase
        fr = rnd2(cval);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg  <= '0;
            started_reg  <= 1'b0;
            running_reg  <= 1'b0;
            last_rep_reg <= 16'd0;
        end
        else if (cmd.dec)
        begin
            case (op_reg)
                OP_TICK:
                begin
                    if (frame_req)
                        elapsed_reg <= acc_sum[TIME_BITS] ? '1 : acc_sum[TIME_BITS-1:0];
                end
                OP_START:
                begin
                    if (!started_reg)
                    begin
                        started_reg <= 1'b1;
                        running_reg <= 1'b1;
                        elapsed_reg <= TIME_BITS'(val_reg);
                    end
                end
                OP_RESTART:
                begin
                    started_reg <= 1'b1;
                    running_reg <= 1'b1;
                    elapsed_reg <= TIME_BITS'(val_reg);
                end
                OP_STOP:
                begin
                    started_reg <= 1'b0;
                    running_reg <= 1'b0;
                end
                OP_PAUSE:
                begin
                    if (started_reg)
                        running_reg <= 1'b0;
                end
                OP_RESUME:
                begin
                    if (started_reg)
                        running_reg <= 1'b1;
                end
                default: ;
            endcase
        end
        else if (cmd.rep)
        begin
            last_rep_reg <= q_reg[15:0];
            if (stop_reg)
            begin
                started_reg <= 1'b0;
                running_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg  <= opcode;
            val_reg <= value_ms;
        end
        if (cmd.nofr)
        begin
            res_frame_reg <= 1'b0;
            res_pos_reg   <= 16'd0;
            res_frac_reg  <= 16'sd0;
            res_rev_reg   <= 1'b0;
            res_rem_reg   <= 16'sd0;
            res_stop_reg  <= (op_reg == OP_STOP) && started_reg;
        end
        if (cmd.sub)
            t_reg <= (elapsed_reg > dly) ? elapsed_reg - dly : '0;
        if (cmd.chk)
        begin
            q_reg <= '0;
            if (!sts.t_ge_dur)
            begin
                pos_reg  <= t_reg[15:0];
                stop_reg <= 1'b0;
            end
            else
            begin
                pos_reg  <= dur;
                stop_reg <= 1'b1;
            end
        end
        if (cmd.res)
        begin
            if (!rep_neg && (div_q[TIME_BITS-1:0] > rep_ext))
            begin
                pos_reg  <= dur;
                q_reg    <= rep_ext;
                stop_reg <= 1'b1;
            end
            else
            begin
                pos_reg  <= div_r;
                q_reg    <= div_q[TIME_BITS-1:0];
                stop_reg <= 1'b0;
            end
        end
        if (cmd.rev && cfg.auto_reverse && q_reg[0])
            pos_reg <= dur - pos_reg;
        if (cmd.rep)
        begin
            res_frame_reg <= 1'b1;
            res_pos_reg   <= pos_reg;
            res_stop_reg  <= stop_reg;
            res_rev_reg   <= !stop_reg && !sts.rep_zero && (last_rep_reg < q_reg[15:0]);
            if (rep_neg)
                res_rem_reg <= -16'sd1;
            else if (q_reg > rep_ext)
                res_rem_reg <= 16'sd0;
            else
                res_rem_reg <= $signed(16'(cfg.repeat_count - $signed(q_reg[15:0])));
        end
        if (cmd.ldf)
            f_reg <= div_q[16:0];
        if (cmd.mul1 || cmd.mul2 || cmd.mul3)
            prod_reg <= mul_a * mul_b;
        if (cmd.post1)
        begin
            r1_reg <= rq;
            ph_reg <= prod_reg[23:0];
        end
        if (cmd.adj)
        begin
            if (r1_reg < 32'sd23167)
            begin
                d_reg   <= 26'(r1_reg);
                off_reg <= 17'd0;
            end
            else if (r1_reg < 32'sd48549)
            begin
                d_reg   <= 26'(r1_reg - 32'sd35861);
                off_reg <= 17'd45875;
            end
            else if (r1_reg < 32'sd63203)
            begin
                d_reg   <= 26'(r1_reg - 32'sd55876);
                off_reg <= 17'd58982;
            end
            else
            begin
                d_reg   <= 26'(r1_reg - 32'sd68387);
                off_reg <= 17'd62259;
            end
        end
        if (cmd.post2)
        begin
            idx_reg <= (idx_full >= (IW + 1)'(COS_TABLE_DEPTH)) ? '0 : idx_full[IW-1:0];
            case (cfg.curve_select)
                CRV_BOUNCE:     r2_reg <= (rq <<< 3) + $signed({15'd0, off_reg});
                CRV_ANTICIPATE: r2_reg <= rq - 32'(tt_s);
                default:        r2_reg <= rq + 32'(tt_s);
            endcase
        end
        if (cmd.post3)
        begin
            r3_reg  <= rq;
            cos_reg <= cos_rom[idx_reg];
        end
        if (cmd.fin)
        begin
            if (fr > 32'sd32767)
                res_frac_reg <= 16'sd32767;
            else if (fr < -32'sd32768)
                res_frac_reg <= -16'sd32768;
            else
                res_frac_reg <= 16'(fr);
        end
        if (cmd.load_out)
        begin
            o_frame_reg <= res_frame_reg;
            o_pos_reg   <= res_pos_reg;
            o_frac_reg  <= res_frac_reg;
            o_rev_reg   <= res_rev_reg;
            o_rem_reg   <= res_rem_reg;
            o_stop_reg  <= res_stop_reg;
        end
    end

    assign frame_valid       = o_frame_reg;
    assign position_ms       = o_pos_reg;
    assign fraction          = o_frac_reg;
    assign repeat_event      = o_rev_reg;
    assign remaining_repeats = o_rem_reg;
    assign stop_event        = o_stop_reg;

endmodule

>>> hdl/anim_ctrl.sv
module anim_ctrl
    import anim_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [17:0] {
        ST_IDLE  = 18'b000000000000000001,
        ST_DEC   = 18'b000000000000000010,
        ST_SUB   = 18'b000000000000000100,
        ST_CHK   = 18'b000000000000001000,
        ST_DIV1  = 18'b000000000000010000,
        ST_RES   = 18'b000000000000100000,
        ST_REV   = 18'b000000000001000000,
        ST_REP   = 18'b000000000010000000,
        ST_DIV2  = 18'b000000000100000000,
        ST_MUL1  = 18'b000000001000000000,
        ST_POST1 = 18'b000000010000000000,
        ST_ADJ   = 18'b000000100000000000,
        ST_MUL2  = 18'b000001000000000000,
        ST_POST2 = 18'b000010000000000000,
        ST_MUL3  = 18'b000100000000000000,
        ST_POST3 = 18'b001000000000000000,
        ST_FIN   = 18'b010000000000000000,
        ST_OUT   = 18'b100000000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                cmd.dec = 1'b1;
                if (sts.frame_req)
                    state_next = ST_SUB;
                else
                begin
                    cmd.nofr   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (sts.t_ge_dur && !sts.rep_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV1;
                end
                else
                begin
                    cmd.chk    = 1'b1;
                    state_next = ST_REP;
                end
            end
            ST_DIV1:
            begin
                if (sts.div_done)
                    state_next = ST_RES;
            end
            ST_RES:
            begin
                cmd.res    = 1'b1;
                state_next = ST_REV;
            end
            ST_REV:
            begin
                cmd.rev    = 1'b1;
                state_next = ST_REP;
            end
            ST_REP:
            begin
                cmd.rep       = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (sts.div_done)
                begin
                    cmd.ldf    = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_POST1;
            end
            ST_POST1:
            begin
                cmd.post1  = 1'b1;
                state_next = ST_ADJ;
            end
            ST_ADJ:
            begin
                cmd.adj    = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_POST2;
            end
            ST_POST2:
            begin
                cmd.post2  = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = ST_POST3;
            end
            ST_POST3:
            begin
                cmd.post3  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result word overwritten while pending");

    a_take_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DEC))
        else $error("accepted word not decoded");

    a_nofr_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEC && !sts.frame_req) |=> (state_reg == ST_OUT))
        else $error("non-frame word did not go to output");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done)
        else $error("divider reported done right after start");

endmodule

>>> hdl/animation_timeline_with_easing_top.sv
// Channel | Modport            | Word fields
// cmd     | anim_in_if.sink    | opcode[2:0], value_ms[15:0]
// res     | anim_out_if.source | frame_valid, position_ms, fraction, repeat_event,
//         |                    | remaining_repeats, stop_event
// apb     | psel/penable/...   | eight 16-bit-or-less registers at 4*i
//
// Non-frame words (stop, pause, resume, ignored tick/start) go from DEC straight to OUT.
// A frame word runs one bit-serial divide (one quotient bit per cycle) for the fraction, and a
// second one before it when the time passes the duration with a nonzero repeat count.
// One word at a time: cmd.ready is high only while the controller idles.
// A finished word sits in the output register while the next one is taken.
// rst_n is asynchronous, active low; it clears timeline state and sets registers to defaults.
module animation_timeline_with_easing_top
    import anim_pkg::*;
#(
    parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF,
    parameter int TIME_BITS       = TIME_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    anim_in_if.sink     cmd,
    anim_out_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg;
    cmd_t ctl;
    sts_t sts;

    // configuration registers
    anim_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: decode, time split, one or two divides, easing steps, output
    anim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .sts       (sts),
        .cmd       (ctl)
    );

    // timeline state, divider, shared multiplier, cosine table
    anim_dpath #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
        .TIME_BITS       (TIME_BITS)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .opcode            (cmd.opcode),
        .value_ms          (cmd.value_ms),
        .cmd               (ctl),
        .sts               (sts),
        .frame_valid       (res.frame_valid),
        .position_ms       (res.position_ms),
        .fraction          (res.fraction),
        .repeat_event      (res.repeat_event),
        .remaining_repeats (res.remaining_repeats),
        .stop_event        (res.stop_event)
    );

endmodule
